// ----- hdl/lces_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lces_pkg
// shared types and constants of the led color effect sequencer
// ----------------------------------------------------------------------------
package lces_pkg;

    localparam int COLOR_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 3 * COLOR_W;

    typedef enum logic [1:0] {
        MODE_FADE   = 2'd0,
        MODE_SEVEN  = 2'd1,
        MODE_THREE  = 2'd2,
        MODE_STROBE = 2'd3
    } effect_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STROBE_ON_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STROBE_OFF_TICKS = 3'd4;

    localparam logic [COLOR_W-1:0] SEVEN_STEP  = 8'd43;
    localparam logic [COLOR_W-1:0] SEVEN_LIMIT = 8'd200;
    localparam logic [COLOR_W-1:0] THREE_STEP  = 8'd85;
    localparam logic [COLOR_W-1:0] THREE_LIMIT = 8'd100;
    localparam logic [COLOR_W-1:0] FULL_LEVEL  = 8'd255;
    localparam logic [COLOR_W-1:0] HUE_RESET   = 8'd170;

    localparam logic [COLOR_W-1:0] STEP_PERIOD_RESET = 8'd10;
    localparam logic [COLOR_W-1:0] BRIGHTNESS_RESET  = 8'd128;
    localparam logic [COLOR_W-1:0] STROBE_ON_RESET   = 8'd10;
    localparam logic [COLOR_W-1:0] STROBE_OFF_RESET  = 8'd200;

endpackage

// ----- hdl/led_color_effect_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_color_effect_sequencer_core
// steps a hue / saturation / value color once per tick request
// ----------------------------------------------------------------------------
// Each accepted request carries one tick flag and yields one color result in
// the next cycle. A request is taken every cycle while the result register is
// empty or its result is being taken, so the block sustains one request per clock;
// the only limit is the single result register and the downstream tready. The user
// must write registers via the plain cfg write port only while idle (not enforced).
module led_color_effect_sequencer_core
    import lces_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] tick, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [7:0] hue_out, [15:8] saturation_out,
                                             // [23:16] value_out
);

    effect_mode_t       mode_reg;
    logic [COLOR_W-1:0] step_period_reg;
    logic [COLOR_W-1:0] brightness_reg;
    logic [COLOR_W-1:0] strobe_on_reg;
    logic [COLOR_W-1:0] strobe_off_reg;

    logic [COLOR_W-1:0] cnt_reg, cnt_next;
    logic               phase_reg, phase_next;
    logic [COLOR_W-1:0] hue_reg, hue_next;
    logic [COLOR_W-1:0] sat_reg, sat_next;
    logic [COLOR_W-1:0] val_reg, val_next;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic accept;
    logic tick;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign tick     = s_tdata[0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_STROBE;
            step_period_reg <= STEP_PERIOD_RESET;
            brightness_reg  <= BRIGHTNESS_RESET;
            strobe_on_reg   <= STROBE_ON_RESET;
            strobe_off_reg  <= STROBE_OFF_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EFFECT_MODE:      mode_reg        <= effect_mode_t'(cfg_data[1:0]);
                REG_STEP_PERIOD:      step_period_reg <= cfg_data;
                REG_BRIGHTNESS:       brightness_reg  <= cfg_data;
                REG_STROBE_ON_TICKS:  strobe_on_reg   <= cfg_data;
                REG_STROBE_OFF_TICKS: strobe_off_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // effect step
    always_comb begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        hue_next   = hue_reg;
        sat_next   = sat_reg;
        val_next   = val_reg;
        if (tick) begin
            if (mode_reg == MODE_STROBE) begin
                cnt_next = cnt_reg + 8'd1;
                if (!phase_reg) begin
                    if (cnt_reg == strobe_off_reg) begin
                        cnt_next   = 8'd1;
                        val_next   = FULL_LEVEL;
                        sat_next   = FULL_LEVEL;
                        phase_next = 1'b1;
                    end
                end else if (cnt_reg == strobe_on_reg) begin
                    cnt_next   = 8'd1;
                    val_next   = '0;
                    phase_next = 1'b0;
                end
            end else if (cnt_reg == step_period_reg) begin
                cnt_next = '0;
                sat_next = FULL_LEVEL;
                val_next = brightness_reg;
                unique case (mode_reg)
                    MODE_FADE:  hue_next = hue_reg + 8'd1;
                    MODE_SEVEN: hue_next = (hue_reg < SEVEN_LIMIT) ? hue_reg + SEVEN_STEP : '0;
                    default:    hue_next = (hue_reg < THREE_LIMIT) ? hue_reg + THREE_STEP : '0;
                endcase
            end else begin
                cnt_next = cnt_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            hue_reg   <= HUE_RESET;
            sat_reg   <= FULL_LEVEL;
            val_reg   <= FULL_LEVEL;
        end else if (accept) begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            val_reg   <= val_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {val_next, sat_next, hue_next};
        end
    end

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid && m_tdata == {val_reg, sat_reg, hue_reg})
        else $error("result does not match color state after request");

    a_hold_no_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !tick |=> $stable(hue_reg) && $stable(sat_reg) && $stable(val_reg)
            && $stable(cnt_reg))
        else $error("state changed on request without tick");

    a_phase_only_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && tick && mode_reg == MODE_STROBE) |=> $stable(phase_reg))
        else $error("strobe phase changed outside strobe tick");
`endif

endmodule

// ----- verif/led_color_effect_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_color_effect_sequencer_core_tb
// self-checking testbench for the led color effect sequencer core
// ----------------------------------------------------------------------------
// Tick requests are driven on the input stream while a local copy of the effect
// state works out the hue, saturation and value that each request must return.
// Results are matched in order, field by field. Directed tests cover reset,
// every mode, the strobe matches, wide and unused register writes and the
// shared counter. Random phases then reprogram the block while it is idle and
// send tick streams with random gaps and output stalls.
// ----------------------------------------------------------------------------
module led_color_effect_sequencer_core_tb;
    import lces_pkg::*;

    localparam int IDLE_PCT    = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS  = 1350;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [COLOR_W-1:0] val;
        logic [COLOR_W-1:0] sat;
        logic [COLOR_W-1:0] hue;
    } hsv_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // local copy of the effect state
    effect_mode_t       fx_mode;
    logic [COLOR_W-1:0] fx_period;
    logic [COLOR_W-1:0] fx_bright;
    logic [COLOR_W-1:0] fx_on;
    logic [COLOR_W-1:0] fx_off;
    logic [COLOR_W-1:0] fx_count;
    logic               fx_lit;
    hsv_t               fx_color;

    hsv_t color_q[$];
    hsv_t got_color;
    hsv_t want_color;
    int   err_count = 0;
    int   stall_cycles = 0;
    int   rand_sent = 0;
    bit   quiet = 1'b0;

    led_color_effect_sequencer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_color = m_tdata;
            if (color_q.size() == 0) begin
                $error("unexpected result: hue %0d sat %0d val %0d",
                       got_color.hue, got_color.sat, got_color.val);
                err_count++;
            end else begin
                want_color = color_q.pop_front();
                if (got_color.hue !== want_color.hue) begin
                    $error("hue_out: expected %0d, got %0d", want_color.hue, got_color.hue);
                    err_count++;
                end
                if (got_color.sat !== want_color.sat) begin
                    $error("saturation_out: expected %0d, got %0d",
                           want_color.sat, got_color.sat);
                    err_count++;
                end
                if (got_color.val !== want_color.val) begin
                    $error("value_out: expected %0d, got %0d", want_color.val, got_color.val);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("led_color_effect_sequencer_core_tb NOT OK");
            $finish;
        end
    end

    function automatic void reset_effect();
        fx_mode   = MODE_STROBE;
        fx_period = STEP_PERIOD_RESET;
        fx_bright = BRIGHTNESS_RESET;
        fx_on     = STROBE_ON_RESET;
        fx_off    = STROBE_OFF_RESET;
        fx_count  = '0;
        fx_lit    = 1'b0;
        fx_color.hue = HUE_RESET;
        fx_color.sat = FULL_LEVEL;
        fx_color.val = FULL_LEVEL;
    endfunction

    function automatic hsv_t advance_effect(bit tick);
        if (tick) begin
            if (fx_mode == MODE_STROBE) begin
                if (!fx_lit) begin
                    if (fx_count == fx_off) begin
                        fx_count = '0;
                        fx_color.val = FULL_LEVEL;
                        fx_color.sat = FULL_LEVEL;
                        fx_lit = 1'b1;
                    end
                end else if (fx_count == fx_on) begin
                    fx_color.val = '0;
                    fx_lit = 1'b0;
                    fx_count = '0;
                end
                fx_count = fx_count + 1'b1;
            end else if (fx_count == fx_period) begin
                case (fx_mode)
                    MODE_FADE: begin
                        fx_color.hue = fx_color.hue + 1'b1;
                    end
                    MODE_SEVEN: begin
                        fx_color.hue = (fx_color.hue < SEVEN_LIMIT) ?
                                       fx_color.hue + SEVEN_STEP : '0;
                    end
                    default: begin
                        fx_color.hue = (fx_color.hue < THREE_LIMIT) ?
                                       fx_color.hue + THREE_STEP : '0;
                    end
                endcase
                fx_color.sat = FULL_LEVEL;
                fx_color.val = fx_bright;
                fx_count = '0;
            end else begin
                fx_count = fx_count + 1'b1;
            end
        end
        return fx_color;
    endfunction

    // called at a rising edge; leaves s_tvalid high after acceptance
    task automatic send_tick(input bit tick);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, tick};
        do @(posedge aclk); while (!s_tready);
        color_q.push_back(advance_effect(tick));
    endtask

    task automatic send_ticks(input int count, input int hold_pct);
        for (int i = 0; i < count; i++) begin
            send_tick($urandom_range(0, 99) >= hold_pct);
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (color_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_EFFECT_MODE:      fx_mode = effect_mode_t'(data[1:0]);
            REG_STEP_PERIOD:      fx_period = data;
            REG_BRIGHTNESS:       fx_bright = data;
            REG_STROBE_ON_TICKS:  fx_on = data;
            REG_STROBE_OFF_TICKS: fx_off = data;
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return CFG_DATA_W'($urandom_range(0, 4));
            5, 6:    return CFG_DATA_W'($urandom_range(5, 20));
            default: return CFG_DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_results_done();
    endtask

    task automatic test_color_modes();
        // upper bits of the mode write are dropped
        write_reg(REG_EFFECT_MODE, 8'hfc);
        write_reg(REG_STEP_PERIOD, 8'd0);
        write_reg(REG_BRIGHTNESS, 8'd255);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_results_done();
        write_reg(REG_EFFECT_MODE, 8'h05);
        write_reg(REG_BRIGHTNESS, 8'd0);
        repeat (4) send_tick(1'b1);
        wait_results_done();
        write_reg(REG_EFFECT_MODE, 8'h8a);
        write_reg(REG_STEP_PERIOD, 8'd255);
        send_tick(1'b1);
        wait_results_done();
        write_reg(REG_STEP_PERIOD, 8'd0);
        repeat (3) send_tick(1'b1);
        wait_results_done();
    endtask

    task automatic test_strobe_edges();
        write_reg(REG_EFFECT_MODE, 8'hff);
        write_reg(REG_STROBE_OFF_TICKS, 8'd0);
        write_reg(REG_STROBE_ON_TICKS, 8'd2);
        repeat (5) send_tick(1'b1);
        wait_results_done();
    endtask

    task automatic test_unused_index();
        for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++) begin
            write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(0, 255)));
        end
        send_tick(1'b1);
        send_tick(1'b1);
        wait_results_done();
    endtask

    task automatic test_shared_counter();
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_FADE));
        write_reg(REG_STEP_PERIOD, 8'd3);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_results_done();
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_SEVEN));
        send_tick(1'b1);
        send_tick(1'b1);
        wait_results_done();
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_STROBE));
        send_tick(1'b1);
        wait_results_done();
    endtask

    task automatic run_random_phase(input int count);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 6) write_reg(REG_STEP_PERIOD, pick_level());
        if ($urandom_range(0, 9) < 6) write_reg(REG_BRIGHTNESS, pick_level());
        if ($urandom_range(0, 9) < 6) write_reg(REG_STROBE_ON_TICKS, pick_level());
        if ($urandom_range(0, 9) < 6) write_reg(REG_STROBE_OFF_TICKS, pick_level());
        if ($urandom_range(0, 9) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      CFG_DATA_W'($urandom_range(0, 255)));
        end
        send_ticks(count, 20);
        rand_sent += count;
        wait_results_done();
    endtask

    task automatic test_random_phases();
        while (rand_sent < RAND_ITEMS) begin
            run_random_phase($urandom_range(30, 90));
        end
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        run_random_phase(150);
        quiet = 1'b0;
    endtask

    initial begin
        reset_effect();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_color_modes();
        test_strobe_edges();
        test_unused_index();
        test_shared_counter();
        test_no_idle();
        test_random_phases();
        wait_results_done();
        repeat (5) @(posedge aclk);
        if (err_count == 0 && color_q.size() == 0) begin
            $display("led_color_effect_sequencer_core_tb OK");
        end else begin
            $display("led_color_effect_sequencer_core_tb NOT OK");
        end
        $finish;
    end

endmodule
